/* sv/est_pkg.sv */
package est_pkg;

  localparam int MAX_POSITION = 255;
  localparam int POS_CAP_I = (MAX_POSITION < 255) ? MAX_POSITION : 255;
  localparam logic [7:0] POS_CAP = POS_CAP_I[7:0];

  localparam int NUM_REGS = 5;
  localparam int REG_IDX_W = 3;

  // delimiter slots, also the configuration register indexes
  localparam logic [REG_IDX_W-1:0] DL_ELEM = 3'd0;
  localparam logic [REG_IDX_W-1:0] DL_COMP = 3'd1;
  localparam logic [REG_IDX_W-1:0] DL_DEC  = 3'd2;
  localparam logic [REG_IDX_W-1:0] DL_REL  = 3'd3;
  localparam logic [REG_IDX_W-1:0] DL_SEG  = 3'd4;

  localparam logic [7:0] RST_ELEM = 8'd43;
  localparam logic [7:0] RST_COMP = 8'd58;
  localparam logic [7:0] RST_DEC  = 8'd46;
  localparam logic [7:0] RST_REL  = 8'd63;
  localparam logic [7:0] RST_SEG  = 8'd39;

  localparam logic [7:0] CHAR_DOT = 8'h2E;

  localparam logic [23:0] TAG_UNA = 24'h554E41;
  localparam logic [23:0] TAG_UNB = 24'h554E42;
  localparam logic [23:0] TAG_UNZ = 24'h554E5A;

  typedef enum logic [4:0] {
    PH_AWAIT = 5'b00001,
    PH_UNA   = 5'b00010,
    PH_FILL  = 5'b00100,
    PH_TAG   = 5'b01000,
    PH_DATA  = 5'b10000
  } phase_t;

  typedef enum logic [1:0] {
    PV_SEG  = 2'd0,
    PV_ELEM = 2'd1,
    PV_COMP = 2'd2
  } prev_delim_t;

  typedef enum logic [1:0] {
    KIND_DATA    = 2'd0,
    KIND_TAG     = 2'd1,
    KIND_DELIM   = 2'd2,
    KIND_SERVICE = 2'd3
  } byte_kind_t;

  typedef enum logic [2:0] {
    EV_NONE      = 3'd0,
    EV_SEG_START = 3'd1,
    EV_ELEM_END  = 3'd2,
    EV_COMP_END  = 3'd3,
    EV_SEG_END   = 3'd4,
    EV_UNA_DONE  = 3'd5
  } event_t;

  localparam logic [2:0] UNA_LAST = 3'd5;

  typedef struct packed {
    logic [7:0]  out_byte;
    byte_kind_t  byte_kind;
    event_t      event_res;
    logic [7:0]  element_pos;
    logic [7:0]  component_pos;
    logic        composite_start;
    logic        composite_end;
    logic        interchange_start;
    logic        interchange_end;
    logic [23:0] segment_tag;
  } result_t;

  function automatic logic is_alnum(input logic [7:0] b);
    return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h5A) ||
           (b >= 8'h61 && b <= 8'h7A);
  endfunction

  function automatic logic [7:0] sat_inc(input logic [7:0] x);
    return (x < POS_CAP) ? x + 8'd1 : x;
  endfunction

endpackage

/* sv/est_core.sv */
module est_core
  import est_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data,
  input  logic                 accept,
  input  logic [7:0]           in_byte,
  output result_t              res
);

  logic [7:0]  regs [NUM_REGS];
  logic [7:0]  delims [NUM_REGS];
  phase_t      phase;
  prev_delim_t prev_delim;
  logic        release_pending;
  logic [23:0] tag_chars;
  logic [1:0]  tag_count;
  logic [7:0]  element_count;
  logic [7:0]  component_count;
  logic [2:0]  una_index;
  logic        interchange_open;

  logic [7:0]  delims_next [NUM_REGS];
  phase_t      phase_next;
  prev_delim_t prev_delim_next;
  logic        release_pending_next;
  logic [23:0] tag_chars_next;
  logic [1:0]  tag_count_next;
  logic [7:0]  element_count_next;
  logic [7:0]  component_count_next;
  logic [2:0]  una_index_next;
  logic        interchange_open_next;

  always_comb begin
    logic [7:0]  b;
    logic [23:0] tag_new;
    logic [7:0]  elem_upd;
    logic [7:0]  comp_upd;
    logic        seg_end;

    b = in_byte;
    tag_new = tag_chars;
    elem_upd = element_count;
    comp_upd = component_count;
    seg_end = 1'b0;

    delims_next = delims;
    phase_next = phase;
    prev_delim_next = prev_delim;
    release_pending_next = release_pending;
    tag_count_next = tag_count;
    una_index_next = una_index;
    interchange_open_next = interchange_open;

    res.out_byte = b;
    res.byte_kind = KIND_SERVICE;
    res.event_res = EV_NONE;
    res.composite_start = 1'b0;
    res.composite_end = 1'b0;
    res.interchange_start = 1'b0;
    res.interchange_end = 1'b0;

    unique case (phase)
      PH_AWAIT, PH_FILL: begin
        if (is_alnum(b)) begin
          if (phase == PH_AWAIT) begin
            delims_next = regs;
          end
          tag_new = {b, 16'd0};
          tag_count_next = 2'd1;
          release_pending_next = 1'b0;
          elem_upd = 8'd0;
          comp_upd = 8'd0;
          phase_next = PH_TAG;
          res.byte_kind = KIND_TAG;
        end
      end
      PH_UNA: begin
        unique case (una_index)
          3'd0: delims_next[DL_COMP] = b;
          3'd1: delims_next[DL_ELEM] = b;
          3'd2: delims_next[DL_DEC] = b;
          3'd3: delims_next[DL_REL] = b;
          3'd4: ;
          default: delims_next[DL_SEG] = b;
        endcase
        if (una_index >= UNA_LAST) begin
          res.event_res = EV_UNA_DONE;
          una_index_next = 3'd0;
          phase_next = PH_FILL;
        end else begin
          una_index_next = una_index + 3'd1;
        end
      end
      PH_TAG: begin
        if (b == delims[DL_ELEM]) begin
          res.byte_kind = KIND_DELIM;
          res.event_res = EV_SEG_START;
          phase_next = PH_DATA;
          prev_delim_next = PV_ELEM;
        end else if (b == delims[DL_SEG]) begin
          res.byte_kind = KIND_DELIM;
          seg_end = 1'b1;
        end else begin
          res.byte_kind = KIND_TAG;
          if (tag_count != 2'd3) begin
            if (tag_count == 2'd1) begin
              tag_new[15:8] = b;
            end else begin
              tag_new[7:0] = b;
            end
            tag_count_next = tag_count + 2'd1;
            // judge the tag on its third character
            if (tag_count == 2'd2) begin
              if (tag_new == TAG_UNA) begin
                res.interchange_end = interchange_open;
                interchange_open_next = 1'b0;
                una_index_next = 3'd0;
                phase_next = PH_UNA;
              end else if (tag_new == TAG_UNB) begin
                if (interchange_open) begin
                  res.interchange_end = 1'b1;
                  delims_next = regs;
                end
                res.interchange_start = 1'b1;
                interchange_open_next = 1'b1;
              end
            end
          end
        end
      end
      default: begin
        if (release_pending) begin
          release_pending_next = 1'b0;
          res.byte_kind = KIND_DATA;
        end else if (b == delims[DL_ELEM] || b == delims[DL_SEG]) begin
          res.byte_kind = KIND_DELIM;
          if (prev_delim == PV_COMP) begin
            comp_upd = sat_inc(component_count);
            res.composite_end = 1'b1;
          end else begin
            elem_upd = sat_inc(element_count);
            comp_upd = 8'd0;
          end
          if (b == delims[DL_ELEM]) begin
            res.event_res = (prev_delim == PV_COMP) ? EV_COMP_END : EV_ELEM_END;
            prev_delim_next = PV_ELEM;
          end else begin
            seg_end = 1'b1;
          end
        end else if (b == delims[DL_COMP]) begin
          res.byte_kind = KIND_DELIM;
          if (prev_delim != PV_COMP) begin
            elem_upd = sat_inc(element_count);
            comp_upd = sat_inc(8'd0);
          end else begin
            comp_upd = sat_inc(component_count);
          end
          res.composite_start = (comp_upd == 8'd1);
          res.event_res = EV_COMP_END;
          prev_delim_next = PV_COMP;
        end else if (b == delims[DL_DEC]) begin
          res.out_byte = CHAR_DOT;
          res.byte_kind = KIND_DATA;
        end else if (b == delims[DL_REL]) begin
          release_pending_next = 1'b1;
        end else begin
          res.byte_kind = KIND_DATA;
        end
      end
    endcase

    tag_chars_next = tag_new;
    res.element_pos = elem_upd;
    res.component_pos = comp_upd;
    res.segment_tag = tag_new;
    element_count_next = elem_upd;
    component_count_next = comp_upd;

    if (seg_end) begin
      res.event_res = EV_SEG_END;
      element_count_next = 8'd0;
      component_count_next = 8'd0;
      prev_delim_next = PV_SEG;
      release_pending_next = 1'b0;
      if (tag_count_next == 2'd3 && tag_new == TAG_UNZ) begin
        res.interchange_end = 1'b1;
        interchange_open_next = 1'b0;
        phase_next = PH_AWAIT;
      end else begin
        phase_next = PH_FILL;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      regs[DL_ELEM] <= RST_ELEM;
      regs[DL_COMP] <= RST_COMP;
      regs[DL_DEC] <= RST_DEC;
      regs[DL_REL] <= RST_REL;
      regs[DL_SEG] <= RST_SEG;
      delims[DL_ELEM] <= RST_ELEM;
      delims[DL_COMP] <= RST_COMP;
      delims[DL_DEC] <= RST_DEC;
      delims[DL_REL] <= RST_REL;
      delims[DL_SEG] <= RST_SEG;
      phase <= PH_AWAIT;
      prev_delim <= PV_SEG;
      release_pending <= 1'b0;
      tag_chars <= '0;
      tag_count <= '0;
      element_count <= '0;
      component_count <= '0;
      una_index <= '0;
      interchange_open <= 1'b0;
    end else begin
      // drop writes past the last register
      if (cfg_we && cfg_index <= DL_SEG) begin
        regs[cfg_index] <= cfg_data;
      end
      if (accept) begin
        delims <= delims_next;
        phase <= phase_next;
        prev_delim <= prev_delim_next;
        release_pending <= release_pending_next;
        tag_chars <= tag_chars_next;
        tag_count <= tag_count_next;
        element_count <= element_count_next;
        component_count <= component_count_next;
        una_index <= una_index_next;
        interchange_open <= interchange_open_next;
      end
    end
  end

  a_una_index_phase: assert property (@(posedge clk) disable iff (rst)
    una_index != 3'd0 |-> phase == PH_UNA)
    else $error("service string index set outside the UNA phase");

  a_release_in_data: assert property (@(posedge clk) disable iff (rst)
    release_pending |-> phase == PH_DATA)
    else $error("release pending outside data");

  a_ubn_opens: assert property (@(posedge clk) disable iff (rst)
    accept && res.interchange_start |=> interchange_open)
    else $error("UNB tag did not open the interchange");

  a_counts_capped: assert property (@(posedge clk) disable iff (rst)
    element_count <= POS_CAP && component_count <= POS_CAP)
    else $error("position count above cap");

endmodule

/* sv/est_outq.sv */
module est_outq
  import est_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_data,
  output logic    full,
  output logic    out_valid,
  input  logic    out_stall,
  output result_t head
);

  result_t    slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       pop;

  assign pop = out_valid && !out_stall;
  assign out_valid = count != 2'd0;
  assign full = count == 2'd2;
  assign head = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      priority if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> count != 2'd2)
    else $error("transfer into a full output queue");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= 2'd2)
    else $error("output queue count out of range");

  a_ptr_track: assert property (@(posedge clk) disable iff (rst)
    (count == 2'd1) == (wr_ptr != rd_ptr))
    else $error("queue pointers disagree with count");

endmodule

/* sv/edifact_segment_tokenizer.sv */
// A result is queued as its byte is transferred in, behind any older result.
// Throughput: one byte per cycle while in_stall is low; all token state updates
// with the input transfer, and a two-entry output queue lets the next byte in while
// a result waits on out_stall. in_stall rises only when both entries are full.
// Reset: synchronous; restores the default delimiter registers and awaits a header.
module edifact_segment_tokenizer
  import est_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           in_byte,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [7:0]           out_byte,
  output logic [1:0]           byte_kind,
  output logic [2:0]           event_res,
  output logic [7:0]           element_pos,
  output logic [7:0]           component_pos,
  output logic                 composite_start,
  output logic                 composite_end,
  output logic                 interchange_start,
  output logic                 interchange_end,
  output logic [23:0]          segment_tag
);

  logic    accept;
  logic    full;
  result_t res;
  result_t head;

  assign in_stall = full;
  assign accept = in_valid && !full;

  est_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .in_byte   (in_byte),
    .res       (res)
  );

  est_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (res),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .head      (head)
  );

  assign out_byte = head.out_byte;
  assign byte_kind = head.byte_kind;
  assign event_res = head.event_res;
  assign element_pos = head.element_pos;
  assign component_pos = head.component_pos;
  assign composite_start = head.composite_start;
  assign composite_end = head.composite_end;
  assign interchange_start = head.interchange_start;
  assign interchange_end = head.interchange_end;
  assign segment_tag = head.segment_tag;

endmodule

/* test/edifact_segment_tokenizer_tb.sv */
module edifact_segment_tokenizer_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import est_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TAIL_CYCLES = 8;
  localparam int PHASE_BYTES = 45;

  class token_checker;
    logic [7:0]  regs [NUM_REGS];
    logic [7:0]  delims [NUM_REGS];
    phase_t      phase;
    prev_delim_t last_delim;
    bit          released;
    logic [23:0] tag;
    int          tag_len;
    logic [7:0]  elem_cnt;
    logic [7:0]  comp_cnt;
    int          svc_idx;
    bit          in_ichg;
    result_t     tokens_due [$];
    int          errors;
    int          checked;

    function new();
      regs = '{RST_ELEM, RST_COMP, RST_DEC, RST_REL, RST_SEG};
      delims = regs;
      phase = PH_AWAIT;
      last_delim = PV_SEG;
      released = 0;
      tag = '0;
      tag_len = 0;
      elem_cnt = '0;
      comp_cnt = '0;
      svc_idx = 0;
      in_ichg = 0;
      errors = 0;
      checked = 0;
    endfunction

    static function bit is_word(logic [7:0] b);
      return (b inside {["0":"9"], ["A":"Z"], ["a":"z"]});
    endfunction

    static function logic [7:0] bump(logic [7:0] n);
      if (n == POS_CAP) return n;
      return n + 8'd1;
    endfunction

    function void set_reg(int idx, logic [7:0] val);
      if (idx < NUM_REGS) regs[idx] = val;
    endfunction

    // work out the token the block must emit for one transferred byte
    function void tokenize_byte(logic [7:0] b);
      result_t r;
      bit      seg_end;
      r = '0;
      r.out_byte = b;
      r.byte_kind = KIND_SERVICE;
      r.event_res = EV_NONE;
      seg_end = 1'b0;
      case (phase)
        PH_AWAIT, PH_FILL: begin
          if (is_word(b)) begin
            if (phase == PH_AWAIT) delims = regs;
            tag = {b, 16'h0000};
            tag_len = 1;
            released = 0;
            elem_cnt = '0;
            comp_cnt = '0;
            phase = PH_TAG;
            r.byte_kind = KIND_TAG;
          end
        end
        PH_UNA: begin
          // service string order: component, element, decimal, release, reserved, terminator
          case (svc_idx)
            0: delims[DL_COMP] = b;
            1: delims[DL_ELEM] = b;
            2: delims[DL_DEC] = b;
            3: delims[DL_REL] = b;
            4: ;
            default: delims[DL_SEG] = b;
          endcase
          if (svc_idx >= UNA_LAST) begin
            r.event_res = EV_UNA_DONE;
            svc_idx = 0;
            phase = PH_FILL;
          end else begin
            svc_idx++;
          end
        end
        PH_TAG: begin
          if (b == delims[DL_ELEM]) begin
            r.byte_kind = KIND_DELIM;
            r.event_res = EV_SEG_START;
            phase = PH_DATA;
            last_delim = PV_ELEM;
          end else if (b == delims[DL_SEG]) begin
            r.byte_kind = KIND_DELIM;
            seg_end = 1'b1;
          end else begin
            r.byte_kind = KIND_TAG;
            if (tag_len < 3) begin
              tag[23 - 8 * tag_len -: 8] = b;
              tag_len++;
              if (tag_len == 3 && tag == TAG_UNA) begin
                r.interchange_end = in_ichg;
                in_ichg = 0;
                svc_idx = 0;
                phase = PH_UNA;
              end else if (tag_len == 3 && tag == TAG_UNB) begin
                if (in_ichg) begin
                  r.interchange_end = 1'b1;
                  delims = regs;
                end
                r.interchange_start = 1'b1;
                in_ichg = 1;
              end
            end
          end
        end
        default: begin
          if (released) begin
            released = 0;
            r.byte_kind = KIND_DATA;
          end else if (b == delims[DL_ELEM]) begin
            r.byte_kind = KIND_DELIM;
            if (last_delim == PV_COMP) begin
              comp_cnt = bump(comp_cnt);
              r.event_res = EV_COMP_END;
              r.composite_end = 1'b1;
            end else begin
              elem_cnt = bump(elem_cnt);
              comp_cnt = '0;
              r.event_res = EV_ELEM_END;
            end
            last_delim = PV_ELEM;
          end else if (b == delims[DL_SEG]) begin
            r.byte_kind = KIND_DELIM;
            if (last_delim == PV_COMP) begin
              comp_cnt = bump(comp_cnt);
              r.composite_end = 1'b1;
            end else begin
              elem_cnt = bump(elem_cnt);
              comp_cnt = '0;
            end
            seg_end = 1'b1;
          end else if (b == delims[DL_COMP]) begin
            r.byte_kind = KIND_DELIM;
            if (last_delim != PV_COMP) begin
              elem_cnt = bump(elem_cnt);
              comp_cnt = '0;
            end
            comp_cnt = bump(comp_cnt);
            r.composite_start = (comp_cnt == 8'd1);
            r.event_res = EV_COMP_END;
            last_delim = PV_COMP;
          end else if (b == delims[DL_DEC]) begin
            r.out_byte = CHAR_DOT;
            r.byte_kind = KIND_DATA;
          end else if (b == delims[DL_REL]) begin
            released = 1;
          end else begin
            r.byte_kind = KIND_DATA;
          end
        end
      endcase

      // positions report the last element before a segment end clears them
      r.element_pos = elem_cnt;
      r.component_pos = comp_cnt;
      if (seg_end) begin
        r.event_res = EV_SEG_END;
        elem_cnt = '0;
        comp_cnt = '0;
        last_delim = PV_SEG;
        released = 0;
        if (tag_len >= 3 && tag == TAG_UNZ) begin
          r.interchange_end = 1'b1;
          in_ichg = 0;
          phase = PH_AWAIT;
        end else begin
          phase = PH_FILL;
        end
      end
      r.segment_tag = tag;
      tokens_due.push_back(r);
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 100) $display("MISMATCH: %s", msg);
    endtask

    task compare(string field, logic [23:0] got, logic [23:0] want);
      if (got !== want)
        report($sformatf("token %0d %s: got %0h, expected %0h", checked, field, got, want));
    endtask

    task check_token(result_t got);
      result_t want;
      if (tokens_due.size() == 0) begin
        report($sformatf("token with nothing due, out_byte %02h", got.out_byte));
        return;
      end
      want = tokens_due.pop_front();
      compare("out_byte", got.out_byte, want.out_byte);
      compare("byte_kind", got.byte_kind, want.byte_kind);
      compare("event_res", got.event_res, want.event_res);
      compare("element_pos", got.element_pos, want.element_pos);
      compare("component_pos", got.component_pos, want.component_pos);
      compare("composite_start", got.composite_start, want.composite_start);
      compare("composite_end", got.composite_end, want.composite_end);
      compare("interchange_start", got.interchange_start, want.interchange_start);
      compare("interchange_end", got.interchange_end, want.interchange_end);
      compare("segment_tag", got.segment_tag, want.segment_tag);
      checked++;
    endtask
  endclass

  typedef enum logic [1:0] {RX_FLOW, RX_LIGHT, RX_HEAVY, RX_BEAT} rx_mode_t;

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [REG_IDX_W-1:0] cfg_index = '0;
  logic [7:0]           cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [7:0]           in_byte = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [7:0]           out_byte;
  logic [1:0]           byte_kind;
  logic [2:0]           event_res;
  logic [7:0]           element_pos;
  logic [7:0]           component_pos;
  logic                 composite_start;
  logic                 composite_end;
  logic                 interchange_start;
  logic                 interchange_end;
  logic [23:0]          segment_tag;

  token_checker sb = new();

  logic [7:0] stream [$];
  logic [7:0] gen_delims [NUM_REGS];
  logic [7:0] cfg_vals [NUM_REGS];
  logic [7:0] una_set [NUM_REGS];

  rx_mode_t rx_mode = RX_FLOW;
  int       rx_left = 0;
  int       quiet = 0;

  edifact_segment_tokenizer dut (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall)
        sb.check_token({out_byte, byte_kind, event_res, element_pos, component_pos,
                        composite_start, composite_end, interchange_start,
                        interchange_end, segment_tag});
      if (in_valid && !in_stall) sb.tokenize_byte(in_byte);
    end
  end

  // receiver backpressure: pick a random stall pattern whenever the last one runs out
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      rx_left = 0;
    end else begin
      if (rx_left == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 3));
        rx_left = $urandom_range(16, 80);
      end
      rx_left--;
      case (rx_mode)
        RX_FLOW:  out_stall <= 1'b0;
        RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        RX_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
        default:  out_stall <= ((rx_left % 5) < 2);
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
    else quiet++;
    if (quiet > WATCHDOG_LIMIT) begin
      $display("edifact_segment_tokenizer_tb: done, errors");
      $finish;
    end
  end

  function automatic logic [7:0] word_char();
    case ($urandom_range(0, 2))
      0: return "0" + 8'($urandom_range(0, 9));
      1: return "A" + 8'($urandom_range(0, 25));
      default: return "a" + 8'($urandom_range(0, 25));
    endcase
  endfunction

  function automatic logic [7:0] filler_byte();
    logic [7:0] b;
    do b = 8'($urandom); while (token_checker::is_word(b));
    return b;
  endfunction

  function automatic logic [7:0] pick_data();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return gen_delims[DL_DEC];
    if (r == 1) return gen_delims[$urandom_range(0, NUM_REGS - 1)];
    if (r < 6) return word_char();
    return 8'($urandom);
  endfunction

  // escape element, segment, component and release characters; the decimal mark goes through as is
  function automatic void add_data(logic [7:0] b);
    if (b == gen_delims[DL_ELEM] || b == gen_delims[DL_SEG] ||
        b == gen_delims[DL_COMP] || b == gen_delims[DL_REL])
      stream.push_back(gen_delims[DL_REL]);
    stream.push_back(b);
  endfunction

  function automatic void push_tag(logic [23:0] t);
    stream.push_back(t[23:16]);
    stream.push_back(t[15:8]);
    stream.push_back(t[7:0]);
  endfunction

  function automatic void add_filler();
    repeat ($urandom_range(0, 2)) stream.push_back(filler_byte());
  endfunction

  function automatic void add_body(int n_elem);
    int n_comp;
    int len;
    for (int e = 0; e < n_elem; e++) begin
      stream.push_back(gen_delims[DL_ELEM]);
      n_comp = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 4) : 1;
      for (int c = 0; c < n_comp; c++) begin
        if (c > 0) stream.push_back(gen_delims[DL_COMP]);
        len = $urandom_range(0, 4);
        for (int k = 0; k < len; k++) add_data(pick_data());
      end
    end
    stream.push_back(gen_delims[DL_SEG]);
  endfunction

  function automatic void add_segment(logic [23:0] t, int n_elem);
    push_tag(t);
    add_body(n_elem);
  endfunction

  function automatic void add_plain_segment();
    logic [23:0] t;
    if ($urandom_range(0, 7) == 0) begin
      // random tag length of one to five characters: short, overlong or three
      repeat ($urandom_range(1, 5)) stream.push_back(word_char());
      add_body($urandom_range(0, 3));
    end else begin
      t = {"A" + 8'($urandom_range(0, 25)), "A" + 8'($urandom_range(0, 25)),
           "A" + 8'($urandom_range(0, 25))};
      if (t == TAG_UNA || t == TAG_UNB || t == TAG_UNZ) t[7:0] = "X";
      add_segment(t, $urandom_range(0, 5));
    end
  endfunction

  function automatic void pick_delims();
    bit clash;
    for (int i = 0; i < NUM_REGS; i++) begin
      do begin
        una_set[i] = filler_byte();
        clash = 0;
        for (int j = 0; j < i; j++)
          if (una_set[j] == una_set[i]) clash = 1;
      end while (clash);
    end
  endfunction

  function automatic void add_interchange(bit with_una, bit closed);
    add_filler();
    if (with_una) begin
      pick_delims();
      push_tag(TAG_UNA);
      stream.push_back(una_set[DL_COMP]);
      stream.push_back(una_set[DL_ELEM]);
      stream.push_back(una_set[DL_DEC]);
      stream.push_back(una_set[DL_REL]);
      stream.push_back(8'($urandom));
      stream.push_back(una_set[DL_SEG]);
      gen_delims = una_set;
      add_filler();
    end else begin
      gen_delims = cfg_vals;
    end
    add_segment(TAG_UNB, $urandom_range(1, 4));
    repeat ($urandom_range(1, 3)) begin
      add_filler();
      add_plain_segment();
    end
    if (closed) begin
      add_filler();
      add_segment(TAG_UNZ, $urandom_range(0, 2));
    end
  endfunction

  function automatic void add_noise(int n);
    repeat (n) begin
      case ($urandom_range(0, 3))
        0: stream.push_back(gen_delims[$urandom_range(0, NUM_REGS - 1)]);
        1: stream.push_back(word_char());
        default: stream.push_back(8'($urandom));
      endcase
    end
  endfunction

  task automatic put_byte(logic [7:0] b);
    in_valid <= 1'b1;
    in_byte <= b;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic pause(int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.tokens_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic send_stream();
    int burst;
    int r;
    burst = 0;
    while (stream.size() != 0) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 40);
        r = $urandom_range(0, 19);
        if (r == 0) drain();
        else if (r > 7) pause($urandom_range(1, 8));
      end
      put_byte(stream.pop_front());
      burst--;
    end
  endtask

  task automatic load_config(input logic [7:0] vals [NUM_REGS], input bit with_stray);
    for (int i = 0; i < NUM_REGS; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= REG_IDX_W'(i);
      cfg_data <= vals[i];
      @(posedge clk);
      sb.set_reg(i, vals[i]);
      cfg_vals[i] = vals[i];
    end
    // indexes past the register list must be ignored
    if (with_stray) begin
      for (int k = NUM_REGS; k < (1 << REG_IDX_W); k++) begin
        cfg_index <= REG_IDX_W'(k);
        cfg_data <= 8'($urandom);
        @(posedge clk);
        sb.set_reg(k, cfg_data);
      end
    end
    cfg_we <= 1'b0;
  endtask

  task automatic run_phase(int target);
    int r;
    while (stream.size() < target) begin
      r = $urandom_range(0, 9);
      if (r == 0) add_noise($urandom_range(1, 12));
      else add_interchange($urandom_range(0, 1), r != 1);
    end
    send_stream();
    drain();
  endtask

  initial begin
    logic [7:0] vals [NUM_REGS];
    logic [7:0] ext [NUM_REGS];
    ext = '{8'h00, 8'hFF, 8'h01, 8'hFE, 8'h7F};
    cfg_vals = '{RST_ELEM, RST_COMP, RST_DEC, RST_REL, RST_SEG};
    gen_delims = cfg_vals;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // default delimiters: skip in header wait, composite, release, decimal,
    // UNB reopen, UNA abort, UNZ with nothing open
    stream = '{8'h00, "U", "N", "B", "+", ":", "b", "?", "'", ".", "'", 8'hFF,
               "U", "N", "B", "'", "U", "N", "A", ":", "+", ".", "?", " ", "'",
               "U", "N", "Z", "'"};
    send_stream();
    drain();

    // rotate the extreme values through every register
    for (int p = 0; p < NUM_REGS; p++) begin
      for (int i = 0; i < NUM_REGS; i++) vals[i] = ext[(i + p) % NUM_REGS];
      load_config(vals, p == NUM_REGS - 1);
      run_phase(PHASE_BYTES);
    end

    pick_delims();
    load_config(una_set, 1'b0);
    add_interchange(1'b0, 1'b1);
    run_phase(stream.size() + PHASE_BYTES);

    // arbitrary register values, alphanumerics and duplicates allowed
    for (int i = 0; i < NUM_REGS; i++) vals[i] = 8'($urandom);
    load_config(vals, 1'b0);
    run_phase(PHASE_BYTES);

    vals = '{RST_ELEM, RST_COMP, RST_DEC, RST_REL, RST_SEG};
    load_config(vals, 1'b0);
    run_phase(PHASE_BYTES);

    drain();
    if (sb.errors == 0) begin
      $display("edifact_segment_tokenizer_tb: done, clean");
    end else begin
      $display("edifact_segment_tokenizer_tb: done, errors");
    end
    $finish;
  end

endmodule
